>>> sv/rgb_light_mode_controller_unit_macros.svh
// Assertion macros for the RGB light mode controller checker.
// Used by rlmc_checker only; no other dependencies.
`ifndef RGB_LIGHT_MODE_CONTROLLER_UNIT_MACROS_SVH
`define RGB_LIGHT_MODE_CONTROLLER_UNIT_MACROS_SVH

// Property checked on every rising edge outside of reset.
`define RLMC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define RLMC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/rlmc_pkg.sv
// Shared types, codes and constants of the RGB light mode controller.
// No dependencies; imported by every module of the block.
package rlmc_pkg;

    localparam int unsigned RLMC_FADE_STEPS = 255;
    localparam int unsigned RLMC_DUTY_W     = 8;
    localparam int unsigned RLMC_LOCKOUT_W  = 16;
    localparam int unsigned RLMC_TIMEOUT_W  = 24;
    localparam int unsigned RLMC_STEP_W     = 8;
    localparam int unsigned RLMC_CFG_IDX_W  = 2;

    localparam logic [RLMC_LOCKOUT_W-1:0] RLMC_LOCKOUT_RST = 16'd1000;
    localparam logic [RLMC_TIMEOUT_W-1:0] RLMC_TIMEOUT_RST = 24'd30000;
    localparam logic [RLMC_STEP_W-1:0]    RLMC_STEP_RST    = 8'd10;

    typedef enum logic [2:0] {
        MODE_FADE  = 3'd0,
        MODE_RED   = 3'd1,
        MODE_GREEN = 3'd2,
        MODE_BLUE  = 3'd3,
        MODE_WHITE = 3'd4,
        MODE_OFF   = 3'd5
    } t_mode;

    typedef enum logic [RLMC_CFG_IDX_W-1:0] {
        CFG_BUTTON_LOCKOUT = 2'd0,
        CFG_OFF_TIMEOUT    = 2'd1,
        CFG_FADE_STEP      = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic ms_tick;
        logic button_fall;
        logic pir_rise;
        logic pir_level;
    } t_in_item;

    typedef struct packed {
        logic [RLMC_DUTY_W-1:0] red_duty;
        logic [RLMC_DUTY_W-1:0] green_duty;
        logic [RLMC_DUTY_W-1:0] blue_duty;
        logic [2:0]             light_mode;
        logic                   lamp_lit;
    } t_out_item;

    typedef struct packed {
        logic [RLMC_LOCKOUT_W-1:0] button_lockout_ms;
        logic [RLMC_TIMEOUT_W-1:0] off_timeout_ms;
        logic [RLMC_STEP_W-1:0]    fade_step_ms;
    } t_cfg;

    // Mode queued by a button press; unused codes wrap to fade.
    function automatic t_mode next_mode(input t_mode cur);
        t_mode nxt;
        unique case (cur)
            MODE_FADE:  nxt = MODE_RED;
            MODE_RED:   nxt = MODE_GREEN;
            MODE_GREEN: nxt = MODE_BLUE;
            MODE_BLUE:  nxt = MODE_WHITE;
            MODE_WHITE: nxt = MODE_OFF;
            default:    nxt = MODE_FADE;
        endcase
        return nxt;
    endfunction

endpackage

>>> sv/rlmc_cfg_regs.sv
// Configuration register file: lockout, off timeout and fade step period.
// Depends on rlmc_pkg.
module rlmc_cfg_regs
    import rlmc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [RLMC_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RLMC_TIMEOUT_W-1:0] i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.button_lockout_ms <= RLMC_LOCKOUT_RST;
            r_cfg.off_timeout_ms    <= RLMC_TIMEOUT_RST;
            r_cfg.fade_step_ms      <= RLMC_STEP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BUTTON_LOCKOUT: begin
                    r_cfg.button_lockout_ms <= i_cfg_data[RLMC_LOCKOUT_W-1:0];
                end
                CFG_OFF_TIMEOUT: begin
                    r_cfg.off_timeout_ms <= i_cfg_data;
                end
                CFG_FADE_STEP: begin
                    r_cfg.fade_step_ms <= i_cfg_data[RLMC_STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> sv/rlmc_core.sv
// Control state and per-item update: events, elapsed counters, fade, control pass.
// Holds the result register. Depends on rlmc_pkg.
module rlmc_core
    import rlmc_pkg::*;
#(
    parameter int unsigned FADE_STEPS = RLMC_FADE_STEPS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    localparam logic [7:0] FADE_LAST = 8'(FADE_STEPS);

    t_mode                     r_active,  n_active;
    t_mode                     r_queued,  n_queued;
    logic [RLMC_TIMEOUT_W-1:0] r_since_switch, n_since_switch;
    logic [RLMC_LOCKOUT_W-1:0] r_since_button, n_since_button;
    logic                      r_motion,  n_motion;
    logic                      r_light,   n_light;
    logic                      r_manual,  n_manual;
    logic [7:0]                r_red,     n_red;
    logic [7:0]                r_green,   n_green;
    logic [7:0]                r_blue,    n_blue;
    logic [1:0]                r_phase,   n_phase;
    logic [7:0]                r_count,   n_count;
    logic                      r_running, n_running;
    logic [RLMC_STEP_W-1:0]    r_timer,   n_timer;
    logic [RLMC_DUTY_W-1:0]    r_duty_r,  n_duty_r;
    logic [RLMC_DUTY_W-1:0]    r_duty_g,  n_duty_g;
    logic [RLMC_DUTY_W-1:0]    r_duty_b,  n_duty_b;
    t_out_item                 r_result;

    logic                   do_step;
    logic [RLMC_STEP_W-1:0] period;
    logic [RLMC_STEP_W:0]   timer_inc;

    assign period   = (i_cfg.fade_step_ms == '0) ? RLMC_STEP_W'(1) : i_cfg.fade_step_ms;
    assign o_result = r_result;

    always_comb begin
        n_active       = r_active;
        n_queued       = r_queued;
        n_since_switch = r_since_switch;
        n_since_button = r_since_button;
        n_motion       = r_motion;
        n_light        = r_light;
        n_manual       = r_manual;
        n_red          = r_red;
        n_green        = r_green;
        n_blue         = r_blue;
        n_phase        = r_phase;
        n_count        = r_count;
        n_running      = r_running;
        n_timer        = r_timer;
        n_duty_r       = r_duty_r;
        n_duty_g       = r_duty_g;
        n_duty_b       = r_duty_b;
        do_step        = 1'b0;
        timer_inc      = {1'b0, r_timer} + 1'b1;

        // events come before the tick
        if (i_item.button_fall && (r_since_button >= i_cfg.button_lockout_ms)) begin
            n_since_button = '0;
            n_manual       = 1'b1;
            n_queued       = next_mode(r_active);
        end
        if (i_item.pir_rise) begin
            n_motion = 1'b1;
            if (!r_light && !n_manual) begin
                n_queued = MODE_FADE;
            end
        end

        if (i_item.ms_tick) begin
            if (n_since_switch != '1) begin
                n_since_switch = n_since_switch + 1'b1;
            end
            if (n_since_button != '1) begin
                n_since_button = n_since_button + 1'b1;
            end
            // step period elapsed: next step, next phase or end of cycle
            if (r_running) begin
                n_timer = timer_inc[RLMC_STEP_W-1:0];
                if (timer_inc >= {1'b0, period}) begin
                    n_timer = '0;
                    if (r_count >= FADE_LAST) begin
                        n_count = '0;
                        if (r_phase >= 2'd2) begin
                            n_phase   = 2'd0;
                            n_running = 1'b0;
                        end else begin
                            n_phase = r_phase + 1'b1;
                            do_step = 1'b1;
                        end
                    end else begin
                        do_step = 1'b1;
                    end
                end
            end
            // control pass
            if (!n_running) begin
                if (!i_item.pir_level) begin
                    n_motion = 1'b0;
                end
                if (!n_motion && !n_manual && n_light &&
                    (n_since_switch >= i_cfg.off_timeout_ms)) begin
                    n_queued = MODE_OFF;
                end
                if (n_active != n_queued) begin
                    n_since_switch = '0;
                    n_active       = n_queued;
                end
                unique case (n_active)
                    MODE_FADE: begin
                        n_light   = 1'b1;
                        n_running = 1'b1;
                        n_phase   = 2'd0;
                        n_count   = '0;
                        n_timer   = '0;
                        do_step   = 1'b1;
                    end
                    MODE_RED: begin
                        n_light = 1'b1;
                        {n_duty_r, n_duty_g, n_duty_b} = {8'hFF, 8'h00, 8'h00};
                    end
                    MODE_GREEN: begin
                        n_light = 1'b1;
                        {n_duty_r, n_duty_g, n_duty_b} = {8'h00, 8'hFF, 8'h00};
                    end
                    MODE_BLUE: begin
                        n_light = 1'b1;
                        {n_duty_r, n_duty_g, n_duty_b} = {8'h00, 8'h00, 8'hFF};
                    end
                    MODE_WHITE: begin
                        n_light = 1'b1;
                        {n_duty_r, n_duty_g, n_duty_b} = {8'hFF, 8'hFF, 8'hFF};
                    end
                    MODE_OFF: begin
                        n_light  = 1'b0;
                        n_manual = 1'b0;
                        {n_duty_r, n_duty_g, n_duty_b} = '0;
                    end
                    default: begin
                    end
                endcase
            end
        end

        // single cross-fade step: channel phase down, next channel up
        if (do_step) begin
            unique case (n_phase)
                2'd1: begin
                    n_green = r_green - 1'b1;
                    n_blue  = r_blue + 1'b1;
                end
                2'd2: begin
                    n_blue = r_blue - 1'b1;
                    n_red  = r_red + 1'b1;
                end
                default: begin
                    n_red   = r_red - 1'b1;
                    n_green = r_green + 1'b1;
                end
            endcase
            n_count  = n_count + 1'b1;
            n_duty_r = n_red;
            n_duty_g = n_green;
            n_duty_b = n_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active       <= MODE_FADE;
            r_queued       <= MODE_FADE;
            r_since_switch <= '0;
            r_since_button <= '0;
            r_motion       <= 1'b0;
            r_light        <= 1'b0;
            r_manual       <= 1'b1;
            r_red          <= 8'hFF;
            r_green        <= 8'h00;
            r_blue         <= 8'h00;
            r_phase        <= 2'd0;
            r_count        <= '0;
            r_running      <= 1'b0;
            r_timer        <= '0;
            r_duty_r       <= '0;
            r_duty_g       <= '0;
            r_duty_b       <= '0;
        end else if (i_fire) begin
            r_active       <= n_active;
            r_queued       <= n_queued;
            r_since_switch <= n_since_switch;
            r_since_button <= n_since_button;
            r_motion       <= n_motion;
            r_light        <= n_light;
            r_manual       <= n_manual;
            r_red          <= n_red;
            r_green        <= n_green;
            r_blue         <= n_blue;
            r_phase        <= n_phase;
            r_count        <= n_count;
            r_running      <= n_running;
            r_timer        <= n_timer;
            r_duty_r       <= n_duty_r;
            r_duty_g       <= n_duty_g;
            r_duty_b       <= n_duty_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_result.red_duty   <= n_duty_r;
            r_result.green_duty <= n_duty_g;
            r_result.blue_duty  <= n_duty_b;
            r_result.light_mode <= n_active;
            r_result.lamp_lit   <= n_light;
        end
    end

endmodule

>>> sv/rgb_light_mode_controller_unit.sv
// RGB light mode controller, top level: input beat register, handshake control,
// configuration registers and the state update core. Depends on rlmc_pkg,
// rlmc_cfg_regs and rlmc_core.
// An accepted beat passes the input beat register, then the core's result register.
// Throughput: one beat per cycle unless the output side stalls; the update is combinational.
// Reset (i_rst_n low, synchronous): all mode, timer and fade state to power-up values,
// both pipeline stages empty, configuration registers to 1000 / 30000 / 10.
module rgb_light_mode_controller_unit
    import rlmc_pkg::*;
#(
    parameter int unsigned FADE_STEPS = RLMC_FADE_STEPS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input beats
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  t_in_item                  i_in_data,
    // result beats
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_out_item                 o_out_data,
    // configuration writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [RLMC_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RLMC_TIMEOUT_W-1:0] i_cfg_data
);

    t_cfg     cfg;
    logic     r_in_valid;
    t_in_item r_in_data;
    logic     r_out_valid;
    logic     advance;
    logic     in_accept;
    logic     fire;

    // The output stage moves when it is empty or its beat is taken; the input
    // register then hands its beat on, so a new beat is taken every cycle
    // unless the output side stalls with both stages full.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign fire       = advance && r_in_valid;

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance || !r_in_valid) begin
                r_in_valid <= in_accept;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // input payload register, loaded on accept only
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_data <= i_in_data;
        end
    end

    rlmc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // state update and result register
    rlmc_core #(
        .FADE_STEPS (FADE_STEPS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_data),
        .i_cfg    (cfg),
        .o_result (o_out_data)
    );

endmodule

>>> sv/rlmc_checker.sv
// Port-level checker for the RGB light mode controller, bound to the top level.
// Depends on rlmc_pkg and rgb_light_mode_controller_unit_macros.svh.
`include "rgb_light_mode_controller_unit_macros.svh"

module rlmc_checker
    import rlmc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    `RLMC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `RLMC_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "stalled result beat changed")
    `RLMC_ASSERT(a_in_stall, i_clk, i_rst_n, o_in_stall |-> o_out_valid && i_out_stall, "input stalled without output back-pressure")
    `RLMC_ASSERT(a_off_dark, i_clk, i_rst_n, o_out_valid && (o_out_data.light_mode == MODE_OFF) |-> (o_out_data.red_duty == '0) && (o_out_data.green_duty == '0) && (o_out_data.blue_duty == '0) && !o_out_data.lamp_lit, "off mode with light output")
    `RLMC_ASSERT(a_red_lit, i_clk, i_rst_n, o_out_valid && (o_out_data.light_mode == MODE_RED) |-> (o_out_data.red_duty == 8'hFF) && (o_out_data.green_duty == '0) && (o_out_data.blue_duty == '0) && o_out_data.lamp_lit, "red mode with wrong duties")

endmodule

bind rgb_light_mode_controller_unit rlmc_checker u_rlmc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
